FILE: rtl/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] PAD_CODE    = 8'h3D;
    localparam int         QUEUE_DEPTH = 4;

    // One decoded group request from the front to the back
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic        last;
        logic        err;
    } cmd_t;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            v = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            v = 6'd63;
        end
        return v;
    endfunction

endpackage

FILE: rtl/base64_stream_decoder_core.sv
// Streaming base64 decoder: one character accepted per cycle, one byte out per cycle,
// while m_tready is high. Once the fourth character of a group is taken, its first byte
// passes the queue write, the pop into the back end and the output register; a length error shows the same way.
// Throughput: 1 character per cycle sustained while m_tready is high; each group drains 1 to 3 bytes from the
// back end at one byte per cycle, and the request queue absorbs output stalls.
// Reset: rst_n asynchronous, active low; clears the group state, queue and output valid.
module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] code_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] item_end, [1] length_error
);

    localparam int CMD_W = $bits(b64d_pkg::cmd_t);

    logic           accept;
    logic           push, pop;
    logic           q_full, q_empty;
    b64d_pkg::cmd_t front_cmd, back_cmd;
    logic [CMD_W-1:0] q_rd_data;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign back_cmd = b64d_pkg::cmd_t'(q_rd_data);

    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_char (s_tdata),
        .last_char (s_tlast),
        .push      (push),
        .cmd       (front_cmd)
    );

    b64d_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (CMD_W'(front_cmd)),
        .pop     (pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (!q_empty),
        .cmd_in    (back_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/b64d_front.sv
module b64d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          code_char,
    input  logic                last_char,
    output logic                push,
    output b64d_pkg::cmd_t      cmd
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        third_pad_reg, third_pad_next;
    logic [5:0]  v;
    logic        is_pad;
    logic        drop_last, drop_third;

    assign v          = b64d_pkg::sextet_of(code_char);
    assign is_pad     = (code_char == b64d_pkg::PAD_CODE);
    assign drop_last  = last_char && is_pad;
    assign drop_third = last_char && third_pad_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        push           = 1'b0;
        cmd.triple     = {acc_reg, v};
        cmd.count      = 2'd3 - {1'b0, drop_last} - {1'b0, drop_third};
        cmd.last       = last_char;
        cmd.err        = 1'b0;
        if (accept)
        begin
            if (pos_reg != 2'd3)
            begin
                acc_next = {acc_reg[11:0], v};
                if (pos_reg == 2'd2)
                begin
                    third_pad_next = is_pad;
                end
                pos_next = pos_reg + 2'd1;
                if (last_char)
                begin
                    // short message: one error request, start over
                    push           = 1'b1;
                    cmd.triple     = '0;
                    cmd.count      = 2'd1;
                    cmd.last       = 1'b1;
                    cmd.err        = 1'b1;
                    pos_next       = 2'd0;
                    acc_next       = '0;
                    third_pad_next = 1'b0;
                end
            end
            else
            begin
                push           = 1'b1;
                pos_next       = 2'd0;
                acc_next       = '0;
                third_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            acc_reg       <= '0;
            third_pad_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
        end
    end

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> pos_reg == 2'd0 && !third_pad_reg)
        else $error("group state not cleared after last character");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cmd.count != 2'd0)
        else $error("request with zero bytes");
`endif

endmodule

FILE: rtl/b64d_fifo.sv
module b64d_fifo #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: rtl/b64d_back.sv
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_avail,
    input  b64d_pkg::cmd_t      cmd_in,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);

    logic           cmd_valid_reg, cmd_valid_next;
    b64d_pkg::cmd_t cmd_reg;
    logic [1:0]     idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     byte_reg;
    logic           last_reg, item_end_reg, err_reg;
    logic           emit, final_byte;
    logic [7:0]     sel_byte;

    assign emit       = cmd_valid_reg && (!out_valid_reg || m_tready);
    assign final_byte = (idx_reg == cmd_reg.count - 2'd1);
    assign pop        = cmd_avail && (!cmd_valid_reg || (emit && final_byte));

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = cmd_reg.triple[23:16];
            2'd1:    sel_byte = cmd_reg.triple[15:8];
            default: sel_byte = cmd_reg.triple[7:0];
        endcase
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 2'd1;
            if (final_byte)
            begin
                cmd_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cmd_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd_in;
        end
        if (emit)
        begin
            byte_reg     <= sel_byte;
            item_end_reg <= final_byte;
            last_reg     <= final_byte && cmd_reg.last;
            err_reg      <= cmd_reg.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {err_reg, item_end_reg};

`ifndef ASSERT_OFF
    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast && m_tdata == 8'd0)
        else $error("error result must end the message with a zero byte");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |-> idx_reg < cmd_reg.count)
        else $error("byte index past request count");
`endif

endmodule
